### design/tsnf_pkg.sv
package tsnf_pkg;

  // Queue geometry. One slot always stays empty, so a full queue holds QueueDepth-1 notes.
  localparam int unsigned QueueDepth = 32;
  localparam int unsigned PtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  // Fixed field widths.
  localparam int unsigned KindW  = 2;
  localparam int unsigned BatchW = 6;
  localparam int unsigned FreqW  = 16;
  localparam int unsigned DurW   = 16;
  localparam int unsigned FreeW  = 6;
  localparam int unsigned NoteW  = FreqW + DurW;

  // Tone timing. The microsecond tick rate is the dividend of the half-period division.
  localparam int unsigned DivW           = 20;
  localparam int unsigned DivCntW        = $clog2(DivW);
  localparam int unsigned HalfW          = DivW - 1;
  localparam logic [DivW-1:0]  TicksPerSecond = DivW'(1000000);
  localparam logic [FreqW-1:0] MaxFreqReset   = FreqW'(10000);

  typedef enum logic [KindW-1:0] {
    KIND_PUSH = 2'd0,
    KIND_MS   = 2'd1,
    KIND_US   = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic push;
    logic us_tick;
    logic ms_count;
    logic ms_clear;
    logic load_silent;
    logic load_tone;
    logic div_step;
    logic div_finish;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_e kind;
    logic  ms_running;
    logic  queue_empty;
    logic  note_silent;
    logic  div_last;
  } ctrl_sts_t;

endpackage

### design/tsnf_ctrl.sv
module tsnf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  tsnf_pkg::ctrl_sts_t  sts_i,
  output tsnf_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_DIVIDE = 5'b00100,
    S_FINISH = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (sts_i.kind)
          tsnf_pkg::KIND_PUSH: cmd_o.push    = 1'b1;
          tsnf_pkg::KIND_US:   cmd_o.us_tick = 1'b1;
          tsnf_pkg::KIND_MS: begin
            if (sts_i.ms_running) begin
              cmd_o.ms_count = 1'b1;
            end else if (sts_i.queue_empty) begin
              cmd_o.ms_clear = 1'b1;
            end else if (sts_i.note_silent) begin
              cmd_o.load_silent = 1'b1;
            end else begin
              cmd_o.load_tone = 1'b1;
              state_d         = S_DIVIDE;
            end
          end
          default: ;
        endcase
      end
      S_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.div_finish = 1'b1;
        state_d          = S_DONE;
      end
      S_DONE: begin
        // The output register takes the result once the previous beat has left.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_to_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_EXEC))
    else $error("accepted beat did not start execution");

  a_divide_from_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == S_DIVIDE) |-> $past(state_q == S_EXEC && sts_i.kind == tsnf_pkg::KIND_MS))
    else $error("divider started outside a millisecond note load");

  a_div_last_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVIDE && sts_i.div_last) |=> (state_q == S_FINISH))
    else $error("division did not finish after its last step");

  a_done_delivers : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
    else $error("result not presented from an empty output register");

endmodule

### design/tsnf_dp.sv
module tsnf_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tsnf_pkg::FreqW-1:0]          cfg_wdata_i,
  input  logic [tsnf_pkg::KindW-1:0]          kind_i,
  input  logic                                first_of_batch_i,
  input  logic [tsnf_pkg::BatchW-1:0]         batch_count_i,
  input  logic [tsnf_pkg::FreqW-1:0]          frequency_i,
  input  logic [tsnf_pkg::DurW-1:0]           duration_ms_i,
  input  tsnf_pkg::ctrl_cmd_t                 cmd_i,
  output tsnf_pkg::ctrl_sts_t                 sts_o,
  output logic                                push_rejected_o,
  output logic                                pin_level_o,
  output logic                                tone_active_o,
  output logic                                queue_empty_o,
  output logic [tsnf_pkg::FreeW-1:0]          free_slots_o
);

  // Captured input beat.
  tsnf_pkg::kind_e                  kind_q;
  logic                             first_q;
  logic [tsnf_pkg::BatchW-1:0]      count_q;
  logic [tsnf_pkg::FreqW-1:0]       freq_q;
  logic [tsnf_pkg::DurW-1:0]        dur_in_q;

  // Queue.
  logic [tsnf_pkg::NoteW-1:0]       mem_q [tsnf_pkg::QueueDepth];
  logic [tsnf_pkg::NoteW-1:0]       rd_q;
  logic [tsnf_pkg::PtrW-1:0]        wp_q, rp_q;
  logic                             batch_q;
  logic [tsnf_pkg::BatchW-1:0]      left_q;

  // Note timing and tone generation.
  logic [tsnf_pkg::FreqW-1:0]       max_freq_q;
  logic [tsnf_pkg::DurW-1:0]        elapsed_q, cur_dur_q;
  logic [tsnf_pkg::HalfW-1:0]       half_q, period_q;
  logic                             tone_q, level_q;
  logic                             rej_q;

  // Divider.
  logic [tsnf_pkg::FreqW-1:0]       divisor_q;
  logic [tsnf_pkg::FreqW-1:0]       rem_q;
  logic [tsnf_pkg::DivW-1:0]        quo_q;
  logic [tsnf_pkg::DivCntW-1:0]     div_cnt_q;

  logic [tsnf_pkg::CntW-1:0]        free_cnt;
  logic                             empty;
  logic                             push_ba, push_rej, push_wr;
  logic [tsnf_pkg::BatchW-1:0]      push_bl;
  logic [tsnf_pkg::FreqW-1:0]       limit, clamped;
  logic [tsnf_pkg::FreqW:0]         trial, diff;
  logic                             trial_ge;
  logic [tsnf_pkg::HalfW-1:0]       period_inc;

  function automatic logic [tsnf_pkg::PtrW-1:0] advance(input logic [tsnf_pkg::PtrW-1:0] p);
    return (p == tsnf_pkg::PtrW'(tsnf_pkg::QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty = (wp_q == rp_q);

  always_comb begin
    if (empty) begin
      free_cnt = tsnf_pkg::CntW'(tsnf_pkg::QueueDepth);
    end else if (wp_q < rp_q) begin
      free_cnt = tsnf_pkg::CntW'(rp_q - wp_q);
    end else begin
      free_cnt = tsnf_pkg::CntW'(tsnf_pkg::QueueDepth) - tsnf_pkg::CntW'(wp_q - rp_q);
    end
  end

  // Batch admission: a new batch abandons any unfinished one and must leave a slot empty.
  always_comb begin
    push_ba  = batch_q;
    push_bl  = left_q;
    push_rej = 1'b0;
    push_wr  = 1'b0;
    if (first_q) begin
      push_ba = 1'b0;
      push_bl = '0;
      if (count_q != '0 && 32'(count_q) < 32'(free_cnt)) begin
        push_ba = 1'b1;
        push_bl = count_q;
      end
    end
    if (!push_ba || push_bl == '0) begin
      push_ba  = 1'b0;
      push_rej = 1'b1;
    end else begin
      push_wr = 1'b1;
      push_bl = push_bl - 1'b1;
      if (push_bl == '0) begin
        push_ba = 1'b0;
      end
    end
  end

  assign limit   = (max_freq_q == '0) ? tsnf_pkg::FreqW'(1) : max_freq_q;
  assign clamped = (rd_q[tsnf_pkg::FreqW-1:0] > limit) ? limit : rd_q[tsnf_pkg::FreqW-1:0];

  // One restoring division step: shift in the next dividend bit and subtract if it fits.
  assign trial    = {rem_q, quo_q[tsnf_pkg::DivW-1]};
  assign diff     = trial - {1'b0, divisor_q};
  assign trial_ge = (trial >= {1'b0, divisor_q});

  assign period_inc = period_q + 1'b1;

  assign sts_o.kind        = kind_q;
  assign sts_o.ms_running  = (elapsed_q < cur_dur_q);
  assign sts_o.queue_empty = empty;
  assign sts_o.note_silent = (rd_q[tsnf_pkg::FreqW-1:0] == '0);
  assign sts_o.div_last    = (div_cnt_q == tsnf_pkg::DivCntW'(tsnf_pkg::DivW - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && push_wr) begin
      mem_q[wp_q] <= {dur_in_q, freq_q};
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rp_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q   <= tsnf_pkg::kind_e'(kind_i);
      first_q  <= first_of_batch_i;
      count_q  <= batch_count_i;
      freq_q   <= frequency_i;
      dur_in_q <= duration_ms_i;
      rej_q    <= 1'b0;
    end else if (cmd_i.push) begin
      rej_q <= push_rej;
    end
    if (cmd_i.load_tone) begin
      divisor_q <= clamped;
      rem_q     <= '0;
      quo_q     <= tsnf_pkg::TicksPerSecond;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q     <= trial_ge ? diff[tsnf_pkg::FreqW-1:0] : trial[tsnf_pkg::FreqW-1:0];
      quo_q     <= {quo_q[tsnf_pkg::DivW-2:0], trial_ge};
      div_cnt_q <= div_cnt_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      push_rejected_o <= rej_q;
      pin_level_o     <= level_q;
      tone_active_o   <= tone_q;
      queue_empty_o   <= empty;
      free_slots_o    <= tsnf_pkg::FreeW'(free_cnt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      rp_q       <= '0;
      batch_q    <= 1'b0;
      left_q     <= '0;
      max_freq_q <= tsnf_pkg::MaxFreqReset;
      elapsed_q  <= '0;
      cur_dur_q  <= '0;
      half_q     <= '0;
      period_q   <= '0;
      tone_q     <= 1'b0;
      level_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_freq_q <= cfg_wdata_i;
      end
      if (cmd_i.push) begin
        batch_q <= push_ba;
        left_q  <= push_bl;
        if (push_wr) begin
          wp_q <= advance(wp_q);
        end
      end
      if (cmd_i.ms_count) begin
        elapsed_q <= elapsed_q + 1'b1;
      end
      if (cmd_i.ms_clear) begin
        tone_q    <= 1'b0;
        elapsed_q <= '0;
        cur_dur_q <= '0;
        half_q    <= '0;
        period_q  <= '0;
      end
      if (cmd_i.load_silent || cmd_i.load_tone) begin
        cur_dur_q <= rd_q[tsnf_pkg::NoteW-1:tsnf_pkg::FreqW];
        elapsed_q <= '0;
        rp_q      <= advance(rp_q);
      end
      if (cmd_i.load_silent) begin
        // A silent note stops toggling; the pin keeps its level.
        tone_q <= 1'b0;
      end
      if (cmd_i.div_finish) begin
        half_q   <= quo_q[tsnf_pkg::DivW-1:1];
        period_q <= '0;
        tone_q   <= 1'b1;
      end
      if (cmd_i.us_tick && tone_q) begin
        if (period_inc >= half_q) begin
          period_q <= '0;
          level_q  <= ~level_q;
        end else begin
          period_q <= period_inc;
        end
      end
    end
  end

endmodule

### design/tone_sequencer_note_fifo_core.sv
// Channel  Handshake                 Payload
// in       in_valid_i / in_stall_o   kind_i, first_of_batch_i, batch_count_i,
//                                    frequency_i, duration_ms_i
// out      out_valid_o / out_stall_i push_rejected_o, pin_level_o, tone_active_o,
//                                    queue_empty_o, free_slots_o
// cfg      cfg_we_i                  cfg_wdata_i (max_frequency)
//
// Every beat yields one result beat. Pushes, microsecond ticks and millisecond ticks that
// do not load a tone pass through the execute and done states; a millisecond tick that loads
// a tone also passes the 20-step restoring divider that computes the half period and a finish state.
// The output register holds one result, so the next input beat is taken while it waits.
// Reset is asynchronous and active low; the note store itself is not cleared.
// A stalled output holds its result and the finished beat after it waits in the controller.
module tone_sequencer_note_fifo_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tsnf_pkg::FreqW-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tsnf_pkg::KindW-1:0]   kind_i,
  input  logic                         first_of_batch_i,
  input  logic [tsnf_pkg::BatchW-1:0]  batch_count_i,
  input  logic [tsnf_pkg::FreqW-1:0]   frequency_i,
  input  logic [tsnf_pkg::DurW-1:0]    duration_ms_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         push_rejected_o,
  output logic                         pin_level_o,
  output logic                         tone_active_o,
  output logic                         queue_empty_o,
  output logic [tsnf_pkg::FreeW-1:0]   free_slots_o
);

  tsnf_pkg::ctrl_cmd_t cmd;
  tsnf_pkg::ctrl_sts_t sts;

  tsnf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tsnf_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .kind_i           (kind_i),
    .first_of_batch_i (first_of_batch_i),
    .batch_count_i    (batch_count_i),
    .frequency_i      (frequency_i),
    .duration_ms_i    (duration_ms_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .push_rejected_o  (push_rejected_o),
    .pin_level_o      (pin_level_o),
    .tone_active_o    (tone_active_o),
    .queue_empty_o    (queue_empty_o),
    .free_slots_o     (free_slots_o)
  );

endmodule

### tb/tone_sequencer_note_fifo_core_tb.sv
`timescale 1ns / 100ps

module tone_sequencer_note_fifo_core_tb;

  typedef struct {
    tsnf_pkg::kind_e                  kind;
    logic                             first;
    logic [tsnf_pkg::BatchW-1:0]      count;
    logic [tsnf_pkg::FreqW-1:0]       freq;
    logic [tsnf_pkg::DurW-1:0]        dur;
  } note_beat_t;

  typedef struct packed {
    logic                             rejected;
    logic                             pin;
    logic                             tone;
    logic                             empty;
    logic [tsnf_pkg::FreeW-1:0]       free;
  } status_t;

  localparam int unsigned SettleCycles = 40;

  logic                             clk_i = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [tsnf_pkg::FreqW-1:0]       cfg_wdata = '0;
  logic                             in_valid = 1'b0;
  tsnf_pkg::kind_e                  kind_d = tsnf_pkg::KIND_NONE;
  logic                             first_d = 1'b0;
  logic [tsnf_pkg::BatchW-1:0]      count_d = '0;
  logic [tsnf_pkg::FreqW-1:0]       freq_d = '0;
  logic [tsnf_pkg::DurW-1:0]        dur_d = '0;
  logic                             out_stall = 1'b0;
  logic                             in_stall_o;
  logic                             out_valid_o;
  logic                             push_rejected_o;
  logic                             pin_level_o;
  logic                             tone_active_o;
  logic                             queue_empty_o;
  logic [tsnf_pkg::FreeW-1:0]       free_slots_o;

  tone_sequencer_note_fifo_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_d),
    .first_of_batch_i(first_d),
    .batch_count_i   (count_d),
    .frequency_i     (freq_d),
    .duration_ms_i   (dur_d),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .push_rejected_o (push_rejected_o),
    .pin_level_o     (pin_level_o),
    .tone_active_o   (tone_active_o),
    .queue_empty_o   (queue_empty_o),
    .free_slots_o    (free_slots_o)
  );

  always #4 clk_i = ~clk_i;

  // Sequencer state as the block should hold it.
  logic [tsnf_pkg::NoteW-1:0]       note_mem [tsnf_pkg::QueueDepth];
  int unsigned                      wr_slot = 0;
  int unsigned                      rd_slot = 0;
  bit                               batch_open = 1'b0;
  int unsigned                      notes_due = 0;
  logic [tsnf_pkg::DurW-1:0]        ms_elapsed = '0;
  logic [tsnf_pkg::DurW-1:0]        ms_length = '0;
  logic [tsnf_pkg::HalfW-1:0]       half_ticks = '0;
  logic [tsnf_pkg::HalfW-1:0]       tick_count = '0;
  bit                               tone_on = 1'b0;
  bit                               pin_state = 1'b0;
  logic [tsnf_pkg::FreqW-1:0]       freq_limit = tsnf_pkg::MaxFreqReset;

  status_t pending_status[$];
  int unsigned mismatch_count = 0;
  int unsigned beat_total = 0;
  int unsigned notes_offered = 0;
  int unsigned notes_refused = 0;
  int unsigned ms_beats = 0;
  int unsigned us_beats = 0;
  int unsigned tone_loads = 0;
  int unsigned pin_toggles = 0;

  // Sender burst and gap state.
  bit          sender_gaps_on = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  // Receiver stall pattern state.
  int unsigned pattern_left = 0;
  int unsigned stall_mode = 0;
  int unsigned hold_left = 0;
  bit          stall_level = 1'b0;

  function automatic int unsigned slots_free();
    if (wr_slot == rd_slot) return tsnf_pkg::QueueDepth;
    if (wr_slot < rd_slot) return rd_slot - wr_slot;
    return tsnf_pkg::QueueDepth - (wr_slot - rd_slot);
  endfunction

  function automatic int unsigned next_slot(input int unsigned p);
    return (p + 1 >= tsnf_pkg::QueueDepth) ? 0 : p + 1;
  endfunction

  // Returns 1 when the note is refused.
  function automatic logic accept_note(input note_beat_t b);
    if (b.first) begin
      batch_open = 1'b0;
      notes_due = 0;
      if (b.count != 0 && b.count < slots_free()) begin
        batch_open = 1'b1;
        notes_due = b.count;
      end
    end
    if (!batch_open || notes_due == 0) begin
      batch_open = 1'b0;
      return 1'b1;
    end
    note_mem[wr_slot] = {b.dur, b.freq};
    wr_slot = next_slot(wr_slot);
    notes_due--;
    if (notes_due == 0) batch_open = 1'b0;
    return 1'b0;
  endfunction

  function automatic void on_millisecond();
    logic [tsnf_pkg::FreqW-1:0] pitch;
    logic [tsnf_pkg::FreqW-1:0] cap;
    if (ms_elapsed < ms_length) begin
      ms_elapsed++;
      return;
    end
    if (wr_slot == rd_slot) begin
      tone_on = 1'b0;
      ms_elapsed = '0;
      ms_length = '0;
      half_ticks = '0;
      tick_count = '0;
      return;
    end
    pitch = note_mem[rd_slot][tsnf_pkg::FreqW-1:0];
    if (pitch == 0) begin
      tone_on = 1'b0;
    end else begin
      cap = (freq_limit == 0) ? tsnf_pkg::FreqW'(1) : freq_limit;
      if (pitch > cap) pitch = cap;
      half_ticks = tsnf_pkg::HalfW'((int'(tsnf_pkg::TicksPerSecond) / int'(pitch)) / 2);
      tick_count = '0;
      tone_on = 1'b1;
      tone_loads++;
    end
    ms_length = note_mem[rd_slot][tsnf_pkg::NoteW-1:tsnf_pkg::FreqW];
    ms_elapsed = '0;
    rd_slot = next_slot(rd_slot);
  endfunction

  function automatic void on_microsecond();
    if (!tone_on) return;
    tick_count = tick_count + 1'b1;
    if (tick_count >= half_ticks) begin
      tick_count = '0;
      pin_state = !pin_state;
      pin_toggles++;
    end
  endfunction

  function automatic status_t advance_sequencer(input note_beat_t b);
    status_t s;
    s.rejected = 1'b0;
    case (b.kind)
      tsnf_pkg::KIND_PUSH: begin
        s.rejected = accept_note(b);
        notes_offered++;
        if (s.rejected) notes_refused++;
      end
      tsnf_pkg::KIND_MS: begin
        on_millisecond();
        ms_beats++;
      end
      tsnf_pkg::KIND_US: begin
        on_microsecond();
        us_beats++;
      end
      default: ;
    endcase
    s.pin = pin_state;
    s.tone = tone_on;
    s.empty = (wr_slot == rd_slot);
    s.free = tsnf_pkg::FreeW'(slots_free());
    return s;
  endfunction

  function automatic logic [tsnf_pkg::FreqW-1:0] note_pitch();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return tsnf_pkg::FreqW'($urandom);
      2: return freq_limit;
      3: return '1;
      default: return tsnf_pkg::FreqW'($urandom_range(1000, 65535));
    endcase
  endfunction

  function automatic logic [tsnf_pkg::DurW-1:0] note_length();
    if ($urandom_range(0, 15) == 0) return tsnf_pkg::DurW'($urandom_range(4, 40));
    return tsnf_pkg::DurW'($urandom_range(0, 3));
  endfunction

  task automatic send_beat(input note_beat_t b);
    status_t want;
    @(negedge clk_i);
    if (gap_left != 0) begin
      in_valid <= 1'b0;
      repeat (gap_left) @(negedge clk_i);
      gap_left = 0;
    end
    in_valid <= 1'b1;
    kind_d <= b.kind;
    first_d <= b.first;
    count_d <= b.count;
    freq_d <= b.freq;
    dur_d <= b.dur;
    do @(posedge clk_i); while (in_stall_o);
    want = advance_sequencer(b);
    pending_status.push_back(want);
    if (b.kind != tsnf_pkg::KIND_NONE) beat_total++;
    if (sender_gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(0, 10);
        gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_tick(input tsnf_pkg::kind_e k);
    note_beat_t b;
    b.kind = k;
    b.first = 1'($urandom_range(0, 1));
    b.count = tsnf_pkg::BatchW'($urandom_range(0, 32));
    b.freq = tsnf_pkg::FreqW'($urandom);
    b.dur = tsnf_pkg::DurW'($urandom);
    send_beat(b);
  endtask

  task automatic send_note(input logic first, input int unsigned count,
                           input logic [tsnf_pkg::FreqW-1:0] freq,
                           input logic [tsnf_pkg::DurW-1:0] dur);
    note_beat_t b;
    b.kind = tsnf_pkg::KIND_PUSH;
    b.first = first;
    b.count = tsnf_pkg::BatchW'(count);
    b.freq = freq;
    b.dur = dur;
    send_beat(b);
  endtask

  task automatic play_batch(input int unsigned n_notes, input int unsigned announced);
    for (int unsigned i = 0; i < n_notes; i++) begin
      send_note(i == 0, announced, note_pitch(), note_length());
    end
  endtask

  // Stops the sender, waits out every result and lets the block go quiet.
  task automatic settle_block();
    @(negedge clk_i);
    in_valid <= 1'b0;
    gap_left = 0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_max_frequency(input logic [tsnf_pkg::FreqW-1:0] value);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    freq_limit = value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    status_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (pending_status.size() == 0) begin
        mismatch_count++;
        $error("result beat arrived with none pending");
      end else begin
        want = pending_status.pop_front();
        check_field("push_rejected", want.rejected, push_rejected_o);
        check_field("pin_level", want.pin, pin_level_o);
        check_field("tone_active", want.tone, tone_active_o);
        check_field("queue_empty", want.empty, queue_empty_o);
        check_field("free_slots", want.free, free_slots_o);
      end
    end
  end

  // The receiver switches between never stalling, scattered stalls and long stall runs.
  always @(negedge clk_i) begin
    if (pattern_left == 0) begin
      pattern_left = $urandom_range(50, 400);
      stall_mode = $urandom_range(0, 2);
      hold_left = 0;
    end else begin
      pattern_left--;
    end
    case (stall_mode)
      0: stall_level = 1'b0;
      1: stall_level = ($urandom_range(0, 3) == 0);
      default: begin
        if (hold_left == 0) begin
          stall_level = !stall_level;
          hold_left = stall_level ? $urandom_range(1, 12) : $urandom_range(1, 6);
        end else begin
          hold_left--;
        end
      end
    endcase
    out_stall <= stall_level;
  end

  task automatic test_idle_status();
    note_beat_t b;
    b.kind = tsnf_pkg::KIND_NONE;
    b.first = 1'b1;
    b.count = '1;
    b.freq = '1;
    b.dur = '1;
    send_beat(b);
    send_tick(tsnf_pkg::KIND_US);
    send_tick(tsnf_pkg::KIND_MS);
  endtask

  task automatic test_batch_rules();
    send_note(1'b0, 5, 16'd1000, 16'd1);
    send_note(1'b1, 0, 16'd1000, 16'd1);
    send_note(1'b1, 32, 16'd1000, 16'd1);
    send_note(1'b1, 3, 16'hFFFF, 16'd1);
    send_note(1'b0, 3, 16'd0, 16'd0);
    // A new batch drops the one note still owed by the previous batch.
    send_note(1'b1, 1, 16'd440, 16'd0);
    send_note(1'b0, 1, 16'd440, 16'd0);
  endtask

  task automatic test_note_playback();
    settle_block();
    write_max_frequency(16'hFFFF);
    send_tick(tsnf_pkg::KIND_MS);
    repeat (8) send_tick(tsnf_pkg::KIND_US);
    send_tick(tsnf_pkg::KIND_MS);
    send_tick(tsnf_pkg::KIND_MS);
    // The silent note keeps the pin where it was.
    send_tick(tsnf_pkg::KIND_US);
    send_tick(tsnf_pkg::KIND_MS);
    send_tick(tsnf_pkg::KIND_MS);
    send_tick(tsnf_pkg::KIND_MS);
  endtask

  task automatic run_random_traffic(input int unsigned beats);
    int unsigned start_count;
    int unsigned sel;
    int unsigned avail;
    int unsigned n;
    note_beat_t  b;
    start_count = beat_total;
    while (beat_total - start_count < beats) begin
      sel = $urandom_range(0, 99);
      avail = slots_free();
      if (sel < 40 && avail > 1) begin
        case ($urandom_range(0, 3))
          0: n = avail - 1;
          1: n = $urandom_range(1, avail - 1);
          default: n = $urandom_range(1, (avail - 1 < 4) ? avail - 1 : 4);
        endcase
        play_batch(n, n);
      end else if (sel < 52) begin
        case ($urandom_range(0, 4))
          0: play_batch($urandom_range(1, 3), avail);
          1: play_batch($urandom_range(1, 2), 0);
          2: begin
            n = $urandom_range(2, 6);
            play_batch($urandom_range(1, n - 1), n);
          end
          3: begin
            n = $urandom_range(1, 3);
            play_batch(n + 1, n);
          end
          default: begin
            // Stray notes with fully random fields, sent only when nothing can store them.
            b.kind = batch_open ? tsnf_pkg::KIND_NONE : tsnf_pkg::KIND_PUSH;
            b.first = 1'b0;
            b.count = tsnf_pkg::BatchW'($urandom_range(0, 32));
            b.freq = tsnf_pkg::FreqW'($urandom);
            b.dur = tsnf_pkg::DurW'($urandom);
            send_beat(b);
          end
        endcase
      end else if (sel < 94) begin
        send_tick(tsnf_pkg::KIND_MS);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 30);
        repeat (n) send_tick(tsnf_pkg::KIND_US);
      end else if (sel < 97) begin
        send_tick(tsnf_pkg::KIND_NONE);
      end else begin
        send_tick(tsnf_pkg::KIND_MS);
      end
    end
  endtask

  task automatic test_limit_sweep();
    int unsigned limits [5];
    int unsigned beats [5];
    limits = '{65535, 0, 1, $urandom_range(200, 40000), 10000};
    beats = '{300, 100, 80, 250, 220};
    for (int i = 0; i < 5; i++) begin
      settle_block();
      write_max_frequency(tsnf_pkg::FreqW'(limits[i]));
      sender_gaps_on = (i != 1);
      burst_left = 0;
      run_random_traffic(beats[i]);
    end
  endtask

  task automatic test_long_note();
    while (wr_slot != rd_slot || ms_elapsed < ms_length) send_tick(tsnf_pkg::KIND_MS);
    send_note(1'b1, 1, note_pitch() | 16'd1, 16'hFFFF);
    send_tick(tsnf_pkg::KIND_MS);
    repeat (20) send_tick(tsnf_pkg::KIND_US);
    repeat (5) send_tick(tsnf_pkg::KIND_MS);
    send_tick(tsnf_pkg::KIND_US);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk_i);
    test_idle_status();
    test_batch_rules();
    test_note_playback();
    test_limit_sweep();
    test_long_note();
    settle_block();
    $display("Run covered %0d beats: %0d notes offered (%0d refused), %0d ms and %0d us ticks.",
             beat_total, notes_offered, notes_refused, ms_beats, us_beats);
    $display("Tones loaded: %0d, pin toggles: %0d, under five frequency limits.",
             tone_loads, pin_toggles);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### filelist.f
design/tsnf_pkg.sv
design/tsnf_ctrl.sv
design/tsnf_dp.sv
design/tone_sequencer_note_fifo_core.sv
tb/tone_sequencer_note_fifo_core_tb.sv
